[rtl/content_row_bound_finder_macros.svh]
// assertion helpers for the content row bound finder
`ifndef CONTENT_ROW_BOUND_FINDER_MACROS_SVH
`define CONTENT_ROW_BOUND_FINDER_MACROS_SVH

// condition and consequence in the same cycle
`define CRBF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("content_row_bound_finder: same-cycle check failed");

// consequence in the cycle after the condition
`define CRBF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("content_row_bound_finder: next-cycle check failed");

`endif

[rtl/crbf_pkg.sv]
package crbf_pkg;

   // field widths
   localparam int CFG_DIM_W = 13;
   localparam int STEP_W    = 4;
   localparam int MARGIN_W  = 8;
   localparam int PIXEL_W   = 8;
   localparam int TOP_W     = 12;
   localparam int BOTTOM_W  = 13;

   // pixel classification and row test
   localparam logic [PIXEL_W-1:0] WHITE_LEVEL = 8'd255;
   localparam int BLACK_SCALE = 10;

   // largest row step, one bottom class per phase
   localparam int STEP_MAX = 15;

   // register reset values
   localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [STEP_W-1:0]    STEP_RESET   = 4'd5;
   localparam logic [MARGIN_W-1:0]  MARGIN_RESET = 8'd25;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_STEP   = 2'd2,
      CSR_MARGIN = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic row_end;
      logic frame_end;
      logic qualifies;
   } row_status_type;

endpackage

[rtl/content_row_bound_finder.sv]
// channel  | ports                                         | moves
// req      | req_valid, req_stall, req_pixel               | one pixel item, raster order
// rsp      | rsp_valid, rsp_stall, rsp_top_row, rsp_bottom_row,
//          | rsp_top_found, rsp_bottom_found               | one bounds item per frame
// csr      | csr_write, csr_index, csr_data                | register write, restarts frame
//
// one pixel item is taken every cycle unless req_stall holds it; an item waits in the input register
// and its frame result is registered into the result register when the item moves on
// a result is produced only with the last pixel of the frame
// reset (synchronous) loads the register defaults and clears the frame counters and flags
// a stalled result holds the input register, so req_stall rises while both are full
// every register write restarts the frame
`include "content_row_bound_finder_macros.svh"

module content_row_bound_finder
   import crbf_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIXEL_W-1:0]   req_pixel,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [TOP_W-1:0]     rsp_top_row,
   output logic [BOTTOM_W-1:0]  rsp_bottom_row,
   output logic                 rsp_top_found,
   output logic                 rsp_bottom_found,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [CFG_DIM_W-1:0] csr_data
);

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int RW = $clog2(MAX_DIM);
   localparam int EW = (DW > CFG_DIM_W) ? DW : CFG_DIM_W;

   // configuration registers
   logic [CFG_DIM_W-1:0] width_ff;
   logic [CFG_DIM_W-1:0] height_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [MARGIN_W-1:0]  margin_ff;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [PIXEL_W-1:0] in_pixel_ff;

   // frame state
   logic [RW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [DW-1:0]       white_ff, white_in;
   logic [DW-1:0]       black_ff, black_in;
   logic [STEP_W-1:0]   phase_ff, phase_in;
   logic                top_seen_ff, top_seen_in;
   logic [RW-1:0]       top_bound_ff, top_bound_in;
   logic [STEP_MAX-1:0] bot_valid_ff, bot_valid_in;
   logic [DW-1:0]       bot_bound_ff [STEP_MAX];
   logic                bot_we;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TOP_W-1:0]    rsp_top_row_ff;
   logic [BOTTOM_W-1:0] rsp_bottom_row_ff;
   logic                rsp_top_found_ff;
   logic                rsp_bottom_found_ff;

   logic [EW-1:0]       width_ext, height_ext;
   logic [DW-1:0]       width_eff, height_eff;
   logic [STEP_W-1:0]   step_eff;
   logic [STEP_W-1:0]   phase_plus;
   logic                advance;
   logic                out_busy;
   logic                is_white;
   logic [DW-1:0]       white_sum, black_sum;
   row_status_type      status;
   logic [RW-1:0]       row_top_bound;
   logic [DW-1:0]       row_bottom_bound;
   logic                top_cand;
   logic                res_top_found, res_bottom_found;
   logic [RW-1:0]       res_top_row;
   logic [DW-1:0]       res_bottom_row;

   // dimensions: zero taken as one, saturated at the largest frame
   assign width_ext  = EW'(width_ff);
   assign height_ext = EW'(height_ff);
   always_comb begin
      if (width_ext == '0) begin
         width_eff = DW'(1);
      end else if (width_ext > EW'(MAX_DIM)) begin
         width_eff = DW'(MAX_DIM);
      end else begin
         width_eff = DW'(width_ext);
      end
      if (height_ext == '0) begin
         height_eff = DW'(1);
      end else if (height_ext > EW'(MAX_DIM)) begin
         height_eff = DW'(MAX_DIM);
      end else begin
         height_eff = DW'(height_ext);
      end
   end
   assign step_eff   = (step_ff == '0) ? STEP_W'(1) : step_ff;
   assign phase_plus = phase_ff + STEP_W'(1);

   // handshake: the input register moves on unless a result is held
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign advance   = in_valid_ff && !out_busy;
   assign req_stall = in_valid_ff && out_busy;

   // pixel counts including the current item
   assign is_white  = (in_pixel_ff == WHITE_LEVEL);
   assign white_sum = white_ff + DW'(is_white);
   assign black_sum = black_ff + DW'(!is_white);

   crbf_row_eval #(
      .DW(DW),
      .RW(RW)
   ) u_row_eval (
      .width        (width_eff),
      .height       (height_eff),
      .margin       (margin_ff),
      .white_sum    (white_sum),
      .black_sum    (black_sum),
      .column       (col_ff),
      .row          (row_ff),
      .status       (status),
      .top_bound    (row_top_bound),
      .bottom_bound (row_bottom_bound)
   );

   // frame result; the bottom class is the phase of the last row
   assign top_cand = (phase_ff == '0) && status.qualifies;
   always_comb begin
      res_top_found = top_seen_ff || top_cand;
      if (top_seen_ff) begin
         res_top_row = top_bound_ff;
      end else if (top_cand) begin
         res_top_row = row_top_bound;
      end else begin
         res_top_row = '0;
      end
      res_bottom_found = status.qualifies || bot_valid_ff[phase_ff];
      if (status.qualifies) begin
         res_bottom_row = row_bottom_bound;
      end else if (bot_valid_ff[phase_ff]) begin
         res_bottom_row = bot_bound_ff[phase_ff];
      end else begin
         res_bottom_row = height_eff;
      end
   end

   // next frame state
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      white_in     = white_ff;
      black_in     = black_ff;
      phase_in     = phase_ff;
      top_seen_in  = top_seen_ff;
      top_bound_in = top_bound_ff;
      bot_valid_in = bot_valid_ff;
      bot_we       = 1'b0;
      if (csr_write) begin
         col_in       = '0;
         row_in       = '0;
         white_in     = '0;
         black_in     = '0;
         phase_in     = '0;
         top_seen_in  = 1'b0;
         bot_valid_in = '0;
      end else if (advance) begin
         white_in = white_sum;
         black_in = black_sum;
         col_in   = col_ff + RW'(1);
         if (status.row_end) begin
            col_in   = '0;
            white_in = '0;
            black_in = '0;
            row_in   = row_ff + RW'(1);
            phase_in = (phase_plus >= step_eff) ? '0 : phase_plus;
            if (!top_seen_ff && top_cand) begin
               top_seen_in  = 1'b1;
               top_bound_in = row_top_bound;
            end
            if (status.qualifies) begin
               bot_valid_in[phase_ff] = 1'b1;
               bot_we = 1'b1;
            end
            if (status.frame_end) begin
               row_in       = '0;
               phase_in     = '0;
               top_seen_in  = 1'b0;
               bot_valid_in = '0;
            end
         end
      end
   end

   // next handshake state
   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign rsp_valid_in = out_busy || (advance && status.frame_end);

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         step_ff      <= STEP_RESET;
         margin_ff    <= MARGIN_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         white_ff     <= '0;
         black_ff     <= '0;
         phase_ff     <= '0;
         top_seen_ff  <= 1'b0;
         bot_valid_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         white_ff     <= white_in;
         black_ff     <= black_in;
         phase_ff     <= phase_in;
         top_seen_ff  <= top_seen_in;
         bot_valid_ff <= bot_valid_in;
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_WIDTH:  width_ff  <= csr_data;
               CSR_HEIGHT: height_ff <= csr_data;
               CSR_STEP:   step_ff   <= csr_data[STEP_W-1:0];
               CSR_MARGIN: margin_ff <= csr_data[MARGIN_W-1:0];
               default:    width_ff  <= width_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_pixel_ff <= req_pixel;
      end
      top_bound_ff <= top_bound_in;
      if (bot_we) begin
         bot_bound_ff[phase_ff] <= row_bottom_bound;
      end
      if (advance && status.frame_end) begin
         rsp_top_row_ff      <= TOP_W'(res_top_row);
         rsp_bottom_row_ff   <= BOTTOM_W'(res_bottom_row);
         rsp_top_found_ff    <= res_top_found;
         rsp_bottom_found_ff <= res_bottom_found;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_top_row      = rsp_top_row_ff;
   assign rsp_bottom_row   = rsp_bottom_row_ff;
   assign rsp_top_found    = rsp_top_found_ff;
   assign rsp_bottom_found = rsp_bottom_found_ff;

   // checks on counters, frame restart and input stall
   `CRBF_ASSERT_SAME(col_in_range_a, 1'b1, DW'(col_ff) < width_eff)
   `CRBF_ASSERT_SAME(row_in_range_a, 1'b1, DW'(row_ff) < height_eff)
   `CRBF_ASSERT_NEXT(frame_restart_a, advance && status.frame_end, (row_ff == '0) && !top_seen_ff && (bot_valid_ff == '0))
   `CRBF_ASSERT_SAME(stall_when_full_a, req_stall, in_valid_ff && rsp_valid_ff)

endmodule

[rtl/crbf_row_eval.sv]
module crbf_row_eval
   import crbf_pkg::*;
#(
   parameter int DW = 13,
   parameter int RW = 12
) (
   input  logic [DW-1:0]       width,
   input  logic [DW-1:0]       height,
   input  logic [MARGIN_W-1:0] margin,
   input  logic [DW-1:0]       white_sum,
   input  logic [DW-1:0]       black_sum,
   input  logic [RW-1:0]       column,
   input  logic [RW-1:0]       row,
   output row_status_type      status,
   output logic [RW-1:0]       top_bound,
   output logic [DW-1:0]       bottom_bound
);

   localparam int AW = ((DW > MARGIN_W) ? DW : MARGIN_W) + 1;

   logic [DW-1:0]   col_next;
   logic [DW-1:0]   row_next;
   logic [DW+3:0]   black_x10;
   logic [DW:0]     white_x2;
   logic [AW-1:0]   row_a;
   logic [AW-1:0]   margin_a;
   logic [AW-1:0]   height_a;

   // row and frame end from the position counters
   assign col_next = DW'(column) + DW'(1);
   assign row_next = DW'(row) + DW'(1);
   assign status.row_end   = !(col_next < width);
   assign status.frame_end = status.row_end && !(row_next < height);

   // black at least a tenth of the row, white more than half
   assign black_x10 = (DW+4)'(black_sum) * (DW+4)'(BLACK_SCALE);
   assign white_x2  = {white_sum, 1'b0};
   assign status.qualifies = (black_x10 >= (DW+4)'(width)) && (white_x2 > {1'b0, width});

   // bounds widened by the margin where the image allows
   assign row_a    = AW'(row);
   assign margin_a = AW'(margin);
   assign height_a = AW'(height);
   assign top_bound = (row_a > margin_a) ? RW'(row_a - margin_a) : row;
   assign bottom_bound = ((height_a - row_a) > margin_a) ? DW'(row_a + margin_a) : DW'(row);

endmodule
